FILE: sv/mpool_pkg.sv
// Shared types and constants for the 3x3 stride-2 max pool with bias add.
package mpool_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_PLANE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PLANE_HEIGHT = 2'd1;
    localparam int         CFG_INDEX_BITS   = 2;
    localparam int         CFG_DATA_BITS    = 13;

    // Register and position widths.
    localparam int PW_BITS    = 8;
    localparam int PH_BITS    = 13;
    localparam int DIM_BITS   = 13;
    localparam int COL_BITS   = 7;
    localparam int ROW_BITS   = 12;
    localparam int OROW_BITS  = 11;
    localparam int OCOL_BITS  = 6;
    localparam int HEIGHT_MAX = 4096;

    // Output queue sizing.
    localparam int OUTQ_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(OUTQ_DEPTH);
    localparam int LVL_BITS   = $clog2(OUTQ_DEPTH) + 1;

    typedef logic [DIM_BITS-1:0] dim_t;
    typedef logic [COL_BITS-1:0] col_t;
    typedef logic [ROW_BITS-1:0] row_t;
    typedef logic [LVL_BITS-1:0] lvl_t;

endpackage

FILE: sv/mpool_outq.sv
// Small output queue that decouples the pool pipeline from the result stream.
module mpool_outq
    import mpool_pkg::*;
#(
    parameter int DATA_BITS = 35
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] din,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_BITS-1:0] dout,
    output lvl_t                 level
);

    logic [DATA_BITS-1:0] q_mem [OUTQ_DEPTH];
    logic [PTR_BITS-1:0]  head_reg;
    logic [PTR_BITS-1:0]  head_next;
    logic [PTR_BITS-1:0]  tail_reg;
    logic [PTR_BITS-1:0]  tail_next;
    lvl_t                 level_reg;
    lvl_t                 level_next;
    logic                 pop;

    assign out_valid = (level_reg != '0);
    assign pop       = out_valid && out_ready;
    assign dout      = q_mem[head_reg];
    assign level     = level_reg;

    // Pointer and fill level updates.
    always_comb
    begin
        head_next  = pop  ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        level_next = level_reg + LVL_BITS'(push) - LVL_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            level_reg <= level_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[tail_reg] <= din;
        end
    end

endmodule

FILE: sv/max_pool_3x3_s2_bias_add.sv
// Top level of the 3x3 stride-2 max pool (padding as minus infinity) with bias add.
//
//  Channel  Direction  Payload                                   Beat when
//  s_*      in         tdata: sample, bias                       s_tvalid & s_tready
//  m_*      out        tdata: pooled, out_row, out_col; tlast    m_tvalid & m_tready
//  cfg_*    in         index, data (plane_width, plane_height)   cfg_valid & cfg_ready
//
// One sample is taken per cycle while s_tready is high. A sample at an odd column reads
// both row stores at the accept edge and writes one of them back in the following
// cycle; results land in a four-entry output queue on the edge after the completing
// sample is taken. s_tready drops only when the queue plus the result in flight would
// fill it. The row stores need no clearing after reset: each plane writes an entry
// before reading it. cfg_ready is always high.
module max_pool_3x3_s2_bias_add
    import mpool_pkg::*;
#(
    parameter int MAX_WIDTH   = 128,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                            clk,
    input  logic                                            rst_n,
    // tdata: sample, bias
    input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0]    s_tdata,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    // tdata: pooled, out_row, out_col
    output logic [((SAMPLE_BITS + 18 + 7) / 8) * 8 - 1:0]   m_tdata,
    output logic                                            m_tlast,
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    input  logic                                            cfg_valid,
    output logic                                            cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]                       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                        cfg_data
);

    localparam int   DEPTH  = MAX_WIDTH / 2;
    localparam int   IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int   M_W    = ((SAMPLE_BITS + 18 + 7) / 8) * 8;
    localparam int   POOL_W = SAMPLE_BITS + 1;
    localparam int   RES_W  = POOL_W + OROW_BITS + OCOL_BITS;
    localparam int   Q_W    = RES_W + 1;
    localparam dim_t MAXW_EVEN = DIM_BITS'(MAX_WIDTH) & ~dim_t'(1);
    localparam dim_t HMAX      = DIM_BITS'(HEIGHT_MAX);

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;

    // Configuration registers.
    logic [PW_BITS-1:0] pw_reg;
    logic [PH_BITS-1:0] ph_reg;

    // Position and horizontal state.
    col_t col_reg;
    col_t col_next;
    row_t row_reg;
    row_t row_next;
    smp_t hp_reg;
    smp_t hp_next;
    smp_t prev_odd_reg;
    smp_t prev_odd_next;

    // Read-modify-write stage.
    logic                 s1_valid_reg;
    logic                 s1_odd_row_reg;
    logic                 s1_row0_reg;
    smp_t                 s1_hm_reg;
    smp_t                 s1_bias_reg;
    logic [IDX_W-1:0]     s1_oc_reg;
    logic [OROW_BITS-1:0] s1_orow_reg;
    logic [OCOL_BITS-1:0] s1_ocol_reg;
    logic                 s1_last_reg;

    // Row stores and their registered read data.
    smp_t wa_mem [DEPTH];
    smp_t cr_mem [DEPTH];
    smp_t wa_rd;
    smp_t cr_rd;

    // Front-end signals.
    logic             accept;
    dim_t             w_raw;
    dim_t             h_raw;
    dim_t             eff_w;
    dim_t             eff_h;
    logic             col_wrap;
    col_t             cur_col;
    dim_t             row_inc;
    dim_t             cur_row13;
    row_t             cur_row;
    dim_t             nxt_col13;
    dim_t             nxt_row13;
    smp_t             s_in;
    smp_t             b_in;
    smp_t             hm;
    logic [IDX_W-1:0] oc;
    logic             odd_col;
    logic             last;

    // Back-end signals.
    smp_t                    wa_new;
    smp_t                    win_max;
    logic signed [POOL_W-1:0] pooled;
    logic                    push;
    logic [Q_W-1:0]          q_din;
    logic [Q_W-1:0]          q_dout;
    lvl_t                    q_level;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign s_in      = s_tdata[SAMPLE_BITS-1:0];
    assign b_in      = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg <= PW_BITS'(112);
            ph_reg <= PH_BITS'(112);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PLANE_WIDTH:  pw_reg <= cfg_data[PW_BITS-1:0];
                REG_PLANE_HEIGHT: ph_reg <= cfg_data[PH_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Effective plane size: low bit cleared, clamped to the legal range.
    always_comb
    begin
        w_raw = DIM_BITS'({pw_reg[PW_BITS-1:1], 1'b0});
        h_raw = {ph_reg[PH_BITS-1:1], 1'b0};
        if (w_raw < dim_t'(2))
            eff_w = dim_t'(2);
        else if (w_raw > DIM_BITS'(MAX_WIDTH))
            eff_w = MAXW_EVEN;
        else
            eff_w = w_raw;
        if (h_raw < dim_t'(2))
            eff_h = dim_t'(2);
        else if (h_raw > HMAX)
            eff_h = HMAX;
        else
            eff_h = h_raw;
    end

    // Position of the incoming sample and of the one after it.
    always_comb
    begin
        col_wrap  = (DIM_BITS'(col_reg) >= eff_w);
        cur_col   = col_wrap ? '0 : col_reg;
        row_inc   = DIM_BITS'(row_reg) + dim_t'(col_wrap);
        cur_row13 = (row_inc >= eff_h) ? '0 : row_inc;
        cur_row   = cur_row13[ROW_BITS-1:0];
        nxt_col13 = DIM_BITS'(cur_col) + dim_t'(1);
        nxt_row13 = DIM_BITS'(cur_row) + dim_t'(1);
        if (nxt_col13 >= eff_w)
        begin
            col_next = '0;
            row_next = (nxt_row13 >= eff_h) ? '0 : nxt_row13[ROW_BITS-1:0];
        end
        else
        begin
            col_next = nxt_col13[COL_BITS-1:0];
            row_next = cur_row;
        end
        odd_col = cur_col[0];
        oc      = IDX_W'(cur_col[COL_BITS-1:1]);
        last    = (cur_row13 == eff_h - dim_t'(1)) &&
                  (DIM_BITS'(cur_col) == eff_w - dim_t'(1));
    end

    // Horizontal 3-wide maximum.
    always_comb
    begin
        hm            = (hp_reg > s_in) ? hp_reg : s_in;
        hp_next       = hp_reg;
        prev_odd_next = prev_odd_reg;
        if (!odd_col)
        begin
            if (cur_col == '0)
                hp_next = s_in;
            else
                hp_next = (prev_odd_reg > s_in) ? prev_odd_reg : s_in;
        end
        else
        begin
            prev_odd_next = s_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            hp_reg       <= '0;
            prev_odd_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && odd_col;
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                hp_reg       <= hp_next;
                prev_odd_reg <= prev_odd_next;
            end
        end
    end

    // Payload of the read-modify-write stage.
    always_ff @(posedge clk)
    begin
        if (accept && odd_col)
        begin
            s1_odd_row_reg <= cur_row[0];
            s1_row0_reg    <= (cur_row == '0);
            s1_hm_reg      <= hm;
            s1_bias_reg    <= b_in;
            s1_oc_reg      <= oc;
            s1_orow_reg    <= cur_row[ROW_BITS-1:1];
            s1_ocol_reg    <= cur_col[COL_BITS-1:1];
            s1_last_reg    <= last;
        end
    end

    // Vertical maximum store: read at accept, written back on even rows.
    always_ff @(posedge clk)
    begin
        if (accept && odd_col)
        begin
            wa_rd <= wa_mem[oc];
        end
        if (s1_valid_reg && !s1_odd_row_reg)
        begin
            wa_mem[s1_oc_reg] <= wa_new;
        end
    end

    // Carried odd-row maximum store: written on odd rows.
    always_ff @(posedge clk)
    begin
        if (accept && odd_col)
        begin
            cr_rd <= cr_mem[oc];
        end
        if (s1_valid_reg && s1_odd_row_reg)
        begin
            cr_mem[s1_oc_reg] <= s1_hm_reg;
        end
    end

    // Window update and result formation.
    always_comb
    begin
        if (s1_row0_reg)
            wa_new = s1_hm_reg;
        else
            wa_new = (cr_rd > s1_hm_reg) ? cr_rd : s1_hm_reg;
        win_max = (wa_rd > s1_hm_reg) ? wa_rd : s1_hm_reg;
        pooled  = POOL_W'(win_max) + POOL_W'(s1_bias_reg);
    end

    assign push  = s1_valid_reg && s1_odd_row_reg;
    assign q_din = {s1_last_reg, s1_ocol_reg, s1_orow_reg, pooled};

    // Accept while the queue can still hold the result in flight and one more.
    assign s_tready = ((q_level + LVL_BITS'(push)) < LVL_BITS'(OUTQ_DEPTH));

    mpool_outq #(
        .DATA_BITS (Q_W)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (q_din),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dout      (q_dout),
        .level     (q_level)
    );

    assign m_tlast = q_dout[Q_W-1];
    assign m_tdata = M_W'(q_dout[RES_W-1:0]);

endmodule

FILE: sv/mpool_chk.sv
// Port-level checker for the max pool block, attached by bind.
module mpool_chk
#(
    parameter int M_W = 40
)
(
    input logic           clk,
    input logic           rst_n,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic [M_W-1:0] m_tdata,
    input logic           m_tlast,
    input logic           m_tvalid,
    input logic           m_tready
);

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result beat changed while stalled");

    // Input is refused only while results are waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

    // A result appears in an empty queue once the beat that completed it has passed the read-modify-write stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result appeared without a completing input beat");

endmodule

bind max_pool_3x3_s2_bias_add mpool_chk #(
    .M_W ($bits(m_tdata))
) u_mpool_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
